// ===== sv/fra_pkg.sv =====
// ----------------------------------------------------------------------------
// fra_pkg
// Shared widths, command and result codes for the fragment reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

   localparam int CHANNELS_DEF    = 2;
   localparam int BLOCK_BYTES_DEF = 32;

   localparam int CMD_W    = 2;
   localparam int KIND_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int SIZE_W   = 8;
   localparam int TIMER_W  = 16;

   localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [TIMER_W-1:0] TIMER_MAX     = 16'hFFFF;

   localparam logic [CMD_W-1:0] CMD_HEADER = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MSG_BYTE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ORPHAN    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ABANDONED = 3'd5;
   localparam logic [KIND_W-1:0] KIND_TIMEOUT   = 3'd6;

endpackage

`default_nettype wire

// ===== sv/fra_if.sv =====
// ----------------------------------------------------------------------------
// fra_if
// Valid/ready channels of the fragment reassembler: request, response, csr.
// ----------------------------------------------------------------------------
`default_nettype none

interface fra_req_if;
   import fra_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic              chan;
   logic              head;
   logic              tail;
   logic [SIZE_W-1:0] frag_size;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, cmd, chan, head, tail, frag_size, data_byte,
                   input ready);
   modport sink   (input valid, cmd, chan, head, tail, frag_size, data_byte,
                   output ready);
endinterface

interface fra_rsp_if;
   import fra_pkg::*;
   logic              valid;
   logic              ready;
   logic              out_chan;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, out_chan, kind, out_byte, last, input ready);
   modport sink   (input valid, out_chan, kind, out_byte, last, output ready);
endinterface

interface fra_csr_if;
   import fra_pkg::*;
   logic               valid;
   logic               ready;
   logic [TIMER_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/fra_msg_buf.sv =====
// ----------------------------------------------------------------------------
// fra_msg_buf
// Message byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_msg_buf #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire  [ADDR_W-1:0]         wr_addr,
   input  wire  [fra_pkg::BYTE_W-1:0] wr_data,
   input  wire                       rd_en,
   input  wire  [ADDR_W-1:0]         rd_addr,
   output logic [fra_pkg::BYTE_W-1:0] rd_data
);
   import fra_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/fragment_reassembler_unit.sv =====
// ----------------------------------------------------------------------------
// fragment_reassembler_unit
// Per-channel reassembly of head/tail-flagged fragments into messages.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  req_port  in    valid/ready      cmd, chan, head, tail, frag_size, data_byte
//  rsp_port  out   valid/ready      out_chan, kind, out_byte, last
//  csr_port  in    valid/ready      data = timeout_ticks
//
//  One item at a time: an item is taken only in idle; each abandon, accept,
//  drop, empty or timeout result then goes out as one response, and each
//  delivered message byte as a buffer read, then output, paced by the single read
//  port of the message buffer. Output stalls hold the sequencer in place.
//  Reset is synchronous; channels come up closed, timeout_ticks at 1000.
//  csr writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembler_unit #(
   parameter int CHANNELS    = fra_pkg::CHANNELS_DEF,
   parameter int BLOCK_BYTES = fra_pkg::BLOCK_BYTES_DEF
) (
   input  wire       clock,
   input  wire       reset,
   fra_req_if.sink   req_port,
   fra_rsp_if.source rsp_port,
   fra_csr_if.sink   csr_port
);
   import fra_pkg::*;

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
   localparam int DEPTH  = CHANNELS * BLOCK_BYTES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic CHAN1_OK = (CHANNELS > 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HDR,
      S_DLV_RD,
      S_DLV_WAIT,
      S_TICK
   } state_type;

   state_type state_ff, state_in;

   logic [CHANNELS-1:0]              open_ff, open_in;
   logic [CHANNELS-1:0][FILL_W-1:0]  fill_ff, fill_in;
   logic [CHANNELS-1:0][TIMER_W-1:0] timer_ff, timer_in;
   logic [CHANNELS-1:0]              to_mask_ff, to_mask_in;

   logic               pend_chan_ff, pend_chan_in;
   logic [SIZE_W-1:0]  pend_left_ff, pend_left_in;
   logic               pend_tail_ff, pend_tail_in;
   logic               pend_drop_ff, pend_drop_in;
   logic [TIMER_W-1:0] timeout_ff, timeout_in;

   logic               ab_pend_ff, ab_pend_in;
   logic               dlv_pend_ff, dlv_pend_in;
   logic [KIND_W-1:0]  main_kind_ff, main_kind_in;
   logic               emit_chan_ff, emit_chan_in;
   logic [ADDR_W-1:0]  dlv_base_ff, dlv_base_in;
   logic [FILL_W-1:0]  dlv_len_ff, dlv_len_in;
   logic [FILL_W-1:0]  dlv_idx_ff, dlv_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_chan_ff, rsp_chan_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [BYTE_W-1:0]  mem_wdata;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [BYTE_W-1:0]  mem_rdata;

   logic               req_fire;
   logic               slot_free;

   fra_msg_buf #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_buf (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_port.ready = (state_ff == S_IDLE);
   assign req_fire       = req_port.valid && (state_ff == S_IDLE);
   assign slot_free      = !rsp_valid_ff || rsp_port.ready;
   assign csr_port.ready = 1'b1;

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.out_chan = rsp_chan_ff;
   assign rsp_port.kind     = rsp_kind_ff;
   assign rsp_port.out_byte = rsp_byte_ff;
   assign rsp_port.last     = rsp_last_ff;

   always_comb begin
      logic [CH_W-1:0]    ch;
      logic [CH_W-1:0]    sel;
      logic               open_v;
      logic [FILL_W-1:0]  fill_v;
      logic [TIMER_W-1:0] t_next;
      logic [TIMER_W-1:0] limit;
      logic [CHANNELS-1:0] mask_v;
      logic               chan_ok;
      logic               last_v;

      state_in     = state_ff;
      open_in      = open_ff;
      fill_in      = fill_ff;
      timer_in     = timer_ff;
      to_mask_in   = to_mask_ff;
      pend_chan_in = pend_chan_ff;
      pend_left_in = pend_left_ff;
      pend_tail_in = pend_tail_ff;
      pend_drop_in = pend_drop_ff;
      timeout_in   = timeout_ff;
      ab_pend_in   = ab_pend_ff;
      dlv_pend_in  = dlv_pend_ff;
      main_kind_in = main_kind_ff;
      emit_chan_in = emit_chan_ff;
      dlv_base_in  = dlv_base_ff;
      dlv_len_in   = dlv_len_ff;
      dlv_idx_in   = dlv_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = req_port.data_byte;
      mem_re       = 1'b0;
      mem_raddr    = dlv_base_ff + ADDR_W'(dlv_idx_ff);
      ch           = '0;
      sel          = '0;
      open_v       = 1'b0;
      fill_v       = '0;
      t_next       = '0;
      limit        = (timeout_ff == '0) ? TIMER_W'(1) : timeout_ff;
      mask_v       = '0;
      chan_ok      = 1'b0;
      last_v       = 1'b0;

      if (csr_port.valid) begin
         timeout_in = csr_port.data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_port.cmd)
                  CMD_HEADER: begin
                     ch           = CH_W'(req_port.chan);
                     chan_ok      = !req_port.chan || CHAN1_OK;
                     pend_chan_in = req_port.chan;
                     pend_left_in = req_port.frag_size;
                     pend_tail_in = req_port.tail;
                     pend_drop_in = 1'b1;
                     emit_chan_in = req_port.chan;
                     ab_pend_in   = 1'b0;
                     dlv_pend_in  = 1'b0;
                     if (chan_ok) begin
                        open_v = open_ff[ch];
                        fill_v = fill_ff[ch];
                        if (req_port.head) begin
                           ab_pend_in   = open_v;
                           open_v       = 1'b1;
                           fill_v       = '0;
                           timer_in[ch] = '0;
                        end
                        open_in[ch] = open_v;
                        fill_in[ch] = fill_v;
                        if (!open_v) begin
                           fill_in[ch]  = '0;
                           timer_in[ch] = '0;
                           main_kind_in = KIND_ORPHAN;
                        end else if ((9'(fill_v) + 9'(req_port.frag_size))
                                     > 9'(BLOCK_BYTES)) begin
                           main_kind_in = KIND_OVERFLOW;
                        end else begin
                           pend_drop_in = 1'b0;
                           timer_in[ch] = '0;
                           main_kind_in = KIND_ACCEPTED;
                           if (req_port.frag_size == '0 && req_port.tail) begin
                              // empty tail fragment: deliver right after the accept
                              dlv_pend_in  = 1'b1;
                              dlv_len_in   = fill_v;
                              dlv_idx_in   = '0;
                              dlv_base_in  = ADDR_W'(ch) * ADDR_W'(BLOCK_BYTES);
                              open_in[ch]  = 1'b0;
                              fill_in[ch]  = '0;
                              timer_in[ch] = '0;
                           end
                        end
                        state_in = S_HDR;
                     end
                  end
                  CMD_BYTE: begin
                     ch      = CH_W'(pend_chan_ff);
                     chan_ok = !pend_chan_ff || CHAN1_OK;
                     if (pend_left_ff != '0) begin
                        pend_left_in = pend_left_ff - SIZE_W'(1);
                        if (!pend_drop_ff && chan_ok && open_ff[ch]) begin
                           fill_v = fill_ff[ch];
                           if (fill_ff[ch] < FILL_W'(BLOCK_BYTES)) begin
                              mem_we    = 1'b1;
                              mem_waddr = ADDR_W'(ch) * ADDR_W'(BLOCK_BYTES)
                                        + ADDR_W'(fill_ff[ch]);
                              fill_v    = fill_ff[ch] + FILL_W'(1);
                           end
                           fill_in[ch] = fill_v;
                           if (pend_left_ff == SIZE_W'(1) && pend_tail_ff) begin
                              emit_chan_in = pend_chan_ff;
                              dlv_len_in   = fill_v;
                              dlv_idx_in   = '0;
                              dlv_base_in  = ADDR_W'(ch) * ADDR_W'(BLOCK_BYTES);
                              open_in[ch]  = 1'b0;
                              fill_in[ch]  = '0;
                              timer_in[ch] = '0;
                              state_in     = S_DLV_RD;
                           end
                        end
                     end
                  end
                  CMD_TICK: begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        if (open_ff[i] && !(pend_left_ff != '0 &&
                                            CH_W'(pend_chan_ff) == CH_W'(i))) begin
                           t_next = (timer_ff[i] == TIMER_MAX) ? timer_ff[i]
                                                               : timer_ff[i] + TIMER_W'(1);
                           if (t_next >= limit) begin
                              open_in[i]  = 1'b0;
                              fill_in[i]  = '0;
                              timer_in[i] = '0;
                              mask_v[i]   = 1'b1;
                           end else begin
                              timer_in[i] = t_next;
                           end
                        end
                     end
                     to_mask_in = mask_v;
                     if (mask_v != '0) begin
                        state_in = S_TICK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HDR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = emit_chan_ff;
               rsp_byte_in  = '0;
               if (ab_pend_ff) begin
                  rsp_kind_in = KIND_ABANDONED;
                  rsp_last_in = 1'b0;
                  ab_pend_in  = 1'b0;
               end else begin
                  rsp_kind_in = main_kind_ff;
                  rsp_last_in = !dlv_pend_ff;
                  state_in    = dlv_pend_ff ? S_DLV_RD : S_IDLE;
               end
            end
         end
         S_DLV_RD: begin
            if (dlv_len_ff == '0) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_chan_in  = emit_chan_ff;
                  rsp_kind_in  = KIND_EMPTY;
                  rsp_byte_in  = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               mem_re   = 1'b1;
               state_in = S_DLV_WAIT;
            end
         end
         S_DLV_WAIT: begin
            // read data holds in the buffer until the next read
            if (slot_free) begin
               last_v       = (dlv_idx_ff + FILL_W'(1)) == dlv_len_ff;
               rsp_valid_in = 1'b1;
               rsp_chan_in  = emit_chan_ff;
               rsp_kind_in  = KIND_MSG_BYTE;
               rsp_byte_in  = mem_rdata;
               rsp_last_in  = last_v;
               dlv_idx_in   = dlv_idx_ff + FILL_W'(1);
               state_in     = last_v ? S_IDLE : S_DLV_RD;
            end
         end
         S_TICK: begin
            if (slot_free) begin
               for (int i = CHANNELS - 1; i >= 0; i--) begin
                  if (to_mask_ff[i]) begin
                     sel = CH_W'(i);
                  end
               end
               mask_v       = to_mask_ff;
               mask_v[sel]  = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_chan_in  = sel[0];
               rsp_kind_in  = KIND_TIMEOUT;
               rsp_byte_in  = '0;
               rsp_last_in  = (mask_v == '0);
               to_mask_in   = mask_v;
               if (mask_v == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      main_kind_ff <= main_kind_in;
      emit_chan_ff <= emit_chan_in;
      dlv_base_ff  <= dlv_base_in;
      dlv_len_ff   <= dlv_len_in;
      dlv_idx_ff   <= dlv_idx_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= '0;
         fill_ff      <= '0;
         timer_ff     <= '0;
         to_mask_ff   <= '0;
         pend_chan_ff <= 1'b0;
         pend_left_ff <= '0;
         pend_tail_ff <= 1'b0;
         pend_drop_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         ab_pend_ff   <= 1'b0;
         dlv_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         fill_ff      <= fill_in;
         timer_ff     <= timer_in;
         to_mask_ff   <= to_mask_in;
         pend_chan_ff <= pend_chan_in;
         pend_left_ff <= pend_left_in;
         pend_tail_ff <= pend_tail_in;
         pend_drop_ff <= pend_drop_in;
         timeout_ff   <= timeout_in;
         ab_pend_ff   <= ab_pend_in;
         dlv_pend_ff  <= dlv_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // consistency checks on per-channel state
   logic closed_nonempty;
   logic fill_too_big;

   always_comb begin
      closed_nonempty = 1'b0;
      fill_too_big    = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (!open_ff[i] && fill_ff[i] != '0) begin
            closed_nonempty = 1'b1;
         end
         if (fill_ff[i] > FILL_W'(BLOCK_BYTES)) begin
            fill_too_big = 1'b1;
         end
      end
   end

   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      !closed_nonempty)
      else $error("closed channel holds buffered bytes");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      !fill_too_big)
      else $error("fill level beyond block size");

   a_dlv_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DLV_WAIT) |-> (dlv_idx_ff < dlv_len_ff))
      else $error("delivery index past message length");

   a_tick_mask: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK) |-> (to_mask_ff != '0))
      else $error("timeout walk with nothing to report");

   a_stray_byte: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_port.cmd == CMD_BYTE && pend_left_ff == '0)
      |=> (state_ff == S_IDLE && $stable(fill_ff)))
      else $error("stray payload byte changed state");

endmodule

`default_nettype wire
